// ----- hw/rtl/owfom_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owfom_pkg
// Shared types, register indexes and constants of the omni-wheel mixer:
// CORDIC gain and arctangent table, register reset values.
// ----------------------------------------------------------------------------
package owfom_pkg;

   // Register map
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_RPM_SCALE  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ARM_LENGTH = 4'd1;

   localparam logic [31:0] RPM_SCALE_RESET  = 32'd65536;
   localparam logic [15:0] ARM_LENGTH_RESET = 16'd256;

   // CORDIC
   localparam int TRIG_BITS_DEFAULT  = 16;
   localparam int CORDIC_MAX_STAGES  = 24;
   localparam int CORDIC_W           = 33;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

   // Wheel sum width: |sum| < 2^41
   localparam int SUM_W = 42;

   typedef struct packed {
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vw;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] front;
      logic signed [15:0] right;
      logic signed [15:0] back;
   } wheels_type;

   typedef logic signed [SUM_W-1:0] sum_type;

   // Arctangent of 2^-i as a fraction of a full turn, 2^32 per turn
   function automatic logic [29:0] atan_turn(input int idx);
      case (idx)
         0:       return 30'd536870912;
         1:       return 30'd316933406;
         2:       return 30'd167458907;
         3:       return 30'd85004756;
         4:       return 30'd42667331;
         5:       return 30'd21354465;
         6:       return 30'd10679838;
         7:       return 30'd5340245;
         8:       return 30'd2670163;
         9:       return 30'd1335087;
         10:      return 30'd667544;
         11:      return 30'd333772;
         12:      return 30'd166886;
         13:      return 30'd83443;
         14:      return 30'd41722;
         15:      return 30'd20861;
         16:      return 30'd10430;
         17:      return 30'd5215;
         18:      return 30'd2608;
         19:      return 30'd1304;
         20:      return 30'd652;
         21:      return 30'd326;
         22:      return 30'd163;
         23:      return 30'd81;
         default: return 30'd0;
      endcase
   endfunction

endpackage

// ----- hw/rtl/owfom_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owfom_if
// Valid/ready channels of the mixer: velocity command in, wheel speeds out,
// and the register write channel.
// ----------------------------------------------------------------------------
interface owfom_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] target_vx;
   logic signed [15:0] target_vy;
   logic signed [15:0] target_vw;
   logic        [15:0] heading;

   modport source (output valid, target_vx, target_vy, target_vw, heading, input ready);
   modport sink   (input valid, target_vx, target_vy, target_vw, heading, output ready);
endinterface

interface owfom_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] wheel_left;
   logic signed [15:0] wheel_front;
   logic signed [15:0] wheel_right;
   logic signed [15:0] wheel_back;

   modport source (output valid, wheel_left, wheel_front, wheel_right, wheel_back,
                   input ready);
   modport sink   (input valid, wheel_left, wheel_front, wheel_right, wheel_back,
                   output ready);
endinterface

interface owfom_csr_if import owfom_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [31:0]            data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/owfom_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owfom_cordic
// Input register, one pipeline stage per CORDIC rotation and a rounding
// stage that yields cosine and sine in Q1.15 for the command's heading.
// ----------------------------------------------------------------------------
module owfom_cordic
   import owfom_pkg::*;
#(
   parameter int TRIG_BITS = TRIG_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   owfom_req_if.sink          req_bus,
   output logic               trig_valid,
   output cmd_type            trig_cmd,
   output logic signed [16:0] trig_cos,
   output logic signed [16:0] trig_sin
);

   localparam int NS = (TRIG_BITS < CORDIC_MAX_STAGES) ? TRIG_BITS : CORDIC_MAX_STAGES;

   logic                       v_ff    [0:NS];
   logic                       flip_ff [0:NS];
   cmd_type                    cmd_ff  [0:NS];
   logic signed [CORDIC_W-1:0] x_ff    [0:NS];
   logic signed [CORDIC_W-1:0] y_ff    [0:NS];
   logic signed [CORDIC_W-1:0] z_ff    [0:NS];
   logic signed [CORDIC_W-1:0] x_in    [1:NS];
   logic signed [CORDIC_W-1:0] y_in    [1:NS];
   logic signed [CORDIC_W-1:0] z_in    [1:NS];

   logic                       flip0_in;
   logic [15:0]                head_adj;
   logic signed [CORDIC_W-1:0] z0_in;

   logic                       rnd_v_ff;
   cmd_type                    rnd_cmd_ff;
   logic signed [16:0]         cos_ff;
   logic signed [16:0]         sin_ff;
   logic signed [16:0]         cos_in;
   logic signed [16:0]         sin_in;

   // Fold the heading into the right half plane; reflected angles negate later
   assign req_bus.ready = en;
   assign flip0_in = (req_bus.heading > 16'h4000) && (req_bus.heading < 16'hC000);
   assign head_adj = flip0_in ? (req_bus.heading - 16'h8000) : req_bus.heading;
   assign z0_in    = $signed({head_adj[15], head_adj, 16'h0000});

   // Rotation step i: shift by i, steer by the sign of the residual angle
   always_comb begin
      for (int i = 0; i < NS; i++) begin
         if (!z_ff[i][CORDIC_W-1]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - $signed({3'b000, atan_turn(i)});
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + $signed({3'b000, atan_turn(i)});
         end
      end
   end

   // Advance valid bits on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NS; i++) v_ff[i] <= 1'b0;
         rnd_v_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_bus.valid;
         for (int i = 1; i <= NS; i++) v_ff[i] <= v_ff[i-1];
         rnd_v_ff <= v_ff[NS];
      end
   end

   // Advance payload on enable
   always_ff @(posedge clock) begin
      if (en) begin
         cmd_ff[0]  <= '{vx: req_bus.target_vx, vy: req_bus.target_vy,
                         vw: req_bus.target_vw};
         flip_ff[0] <= flip0_in;
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_in;
         for (int i = 1; i <= NS; i++) begin
            cmd_ff[i]  <= cmd_ff[i-1];
            flip_ff[i] <= flip_ff[i-1];
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
         end
         rnd_cmd_ff <= cmd_ff[NS];
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
      end
   end

   // Round Q2.30 to Q1.15, clamp, undo the reflection
   always_comb begin
      logic signed [CORDIC_W-1:0] xr;
      logic signed [CORDIC_W-1:0] yr;
      logic signed [15:0]         xc;
      logic signed [15:0]         yc;
      xr = (x_ff[NS] + 33'sd16384) >>> 15;
      yr = (y_ff[NS] + 33'sd16384) >>> 15;
      if (xr[CORDIC_W-1:15] == '0 || xr[CORDIC_W-1:15] == '1) begin
         xc = xr[15:0];
      end else begin
         xc = xr[CORDIC_W-1] ? 16'sh8000 : 16'sh7FFF;
      end
      if (yr[CORDIC_W-1:15] == '0 || yr[CORDIC_W-1:15] == '1) begin
         yc = yr[15:0];
      end else begin
         yc = yr[CORDIC_W-1] ? 16'sh8000 : 16'sh7FFF;
      end
      cos_in = flip_ff[NS] ? -{xc[15], xc} : {xc[15], xc};
      sin_in = flip_ff[NS] ? -{yc[15], yc} : {yc[15], yc};
   end

   assign trig_valid = rnd_v_ff;
   assign trig_cmd   = rnd_cmd_ff;
   assign trig_cos   = cos_ff;
   assign trig_sin   = sin_ff;

endmodule

// ----- hw/rtl/owfom_mix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owfom_mix
// Rotates the command into the chassis frame and mixes it into the four
// wheel sums with 15 fraction bits, over four register stages.
// ----------------------------------------------------------------------------
module owfom_mix
   import owfom_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [15:0]        arm_length,
   input  logic               trig_valid,
   input  cmd_type            trig_cmd,
   input  logic signed [16:0] trig_cos,
   input  logic signed [16:0] trig_sin,
   output logic               mix_valid,
   output sum_type            mix_sum [0:3]
);

   logic               v_ff [0:3];

   logic signed [32:0] pxc_ff, pys_ff, pxs_ff, pyc_ff, prot_ff;
   logic signed [32:0] pxc_in, pys_in, pxs_in, pyc_in, prot_in;
   logic signed [33:0] rx_ff, ry_ff;
   logic signed [39:0] rot_a_ff, rot_b_ff;
   logic signed [34:0] sa_ff, sb_ff;
   logic signed [34:0] sa_in, sb_in;
   sum_type            sum_ff [0:3];
   sum_type            rot_x;
   sum_type            sa_x;
   sum_type            sb_x;

   // Products of the rotation and the rotation-rate term
   assign pxc_in  = $signed(trig_cmd.vx) * trig_cos;
   assign pys_in  = $signed(trig_cmd.vy) * trig_sin;
   assign pxs_in  = $signed(trig_cmd.vx) * trig_sin;
   assign pyc_in  = $signed(trig_cmd.vy) * trig_cos;
   assign prot_in = $signed(trig_cmd.vw) * $signed({1'b0, arm_length});

   // Cross sum and difference of the rotated components
   assign sa_in = {rx_ff[33], rx_ff} + {ry_ff[33], ry_ff};
   assign sb_in = {rx_ff[33], rx_ff} - {ry_ff[33], ry_ff};

   assign rot_x = {{(SUM_W-40){rot_b_ff[39]}}, rot_b_ff};
   assign sa_x  = {{(SUM_W-35){sa_ff[34]}}, sa_ff};
   assign sb_x  = {{(SUM_W-35){sb_ff[34]}}, sb_ff};

   // Advance valid bits on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= trig_valid;
         for (int i = 1; i < 4; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   // Advance payload on enable
   always_ff @(posedge clock) begin
      if (en) begin
         pxc_ff    <= pxc_in;
         pys_ff    <= pys_in;
         pxs_ff    <= pxs_in;
         pyc_ff    <= pyc_in;
         prot_ff   <= prot_in;
         rx_ff     <= {pxc_ff[32], pxc_ff} - {pys_ff[32], pys_ff};
         ry_ff     <= {pxs_ff[32], pxs_ff} + {pyc_ff[32], pyc_ff};
         rot_a_ff  <= {prot_ff, 7'b0000000};
         sa_ff     <= sa_in;
         sb_ff     <= sb_in;
         rot_b_ff  <= rot_a_ff;
         sum_ff[0] <= rot_x + sa_x;
         sum_ff[1] <= rot_x + sb_x;
         sum_ff[2] <= rot_x - sa_x;
         sum_ff[3] <= rot_x - sb_x;
      end
   end

   assign mix_valid = v_ff[3];
   assign mix_sum   = sum_ff;

endmodule

// ----- hw/rtl/owfom_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owfom_scale
// Scales each wheel sum by the Q16.16 rpm factor, rounds to an integer and
// saturates to 16 bits. Two stages: split multiply, then add and clamp.
// ----------------------------------------------------------------------------
module owfom_scale
   import owfom_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic [31:0] rpm_scale,
   input  logic        mix_valid,
   input  sum_type     mix_sum [0:3],
   output logic        scale_valid,
   output wheels_type  scale_wheels
);

   localparam int PROD_W  = SUM_W + 17;
   localparam int TOTAL_W = PROD_W + 17;
   localparam int Q_W     = TOTAL_W - 31;

   logic                      v_ff [0:1];
   logic signed [PROD_W-1:0]  thi_ff [0:3];
   logic signed [PROD_W-1:0]  tlo_ff [0:3];
   logic signed [PROD_W-1:0]  thi_in [0:3];
   logic signed [PROD_W-1:0]  tlo_in [0:3];
   logic signed [15:0]        wheel_ff [0:3];
   logic signed [15:0]        wheel_in [0:3];

   // Split the factor into 16-bit halves for two narrow products per lane
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         thi_in[k] = mix_sum[k] * $signed({1'b0, rpm_scale[31:16]});
         tlo_in[k] = mix_sum[k] * $signed({1'b0, rpm_scale[15:0]});
      end
   end

   // Recombine, round half up at bit 31, clamp to 16 bits
   always_comb begin
      logic signed [TOTAL_W-1:0] tot;
      logic signed [Q_W-1:0]     q;
      for (int k = 0; k < 4; k++) begin
         tot = {thi_ff[k][PROD_W-1], thi_ff[k], 16'h0000}
             + {{17{tlo_ff[k][PROD_W-1]}}, tlo_ff[k]}
             + (TOTAL_W'(1) <<< 30);
         q = tot[TOTAL_W-1:31];
         if (q[Q_W-1:15] == '0 || q[Q_W-1:15] == '1) begin
            wheel_in[k] = q[15:0];
         end else begin
            wheel_in[k] = q[Q_W-1] ? 16'sh8000 : 16'sh7FFF;
         end
      end
   end

   // Advance valid bits on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
         v_ff[1] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= mix_valid;
         v_ff[1] <= v_ff[0];
      end
   end

   // Advance payload on enable
   always_ff @(posedge clock) begin
      if (en) begin
         thi_ff   <= thi_in;
         tlo_ff   <= tlo_in;
         wheel_ff <= wheel_in;
      end
   end

   assign scale_valid  = v_ff[1];
   assign scale_wheels = '{left: wheel_ff[0], front: wheel_ff[1],
                           right: wheel_ff[2], back: wheel_ff[3]};

endmodule

// ----- hw/rtl/owfom_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owfom_outbuf
// Two-entry result buffer. The pipeline advances whenever the buffer is not
// full, so the enable depends on registered state only.
// ----------------------------------------------------------------------------
module owfom_outbuf
   import owfom_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  wheels_type push_wheels,
   output logic       en,
   owfom_rsp_if.source rsp_bus
);

   wheels_type  mem_ff [0:1];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        push;
   logic        pop;

   assign en   = (count_ff != 2'd2);
   assign push = en && push_valid;
   assign pop  = rsp_bus.valid && rsp_bus.ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Track pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   // Store a transfer from the pipeline
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_wheels;
      end
   end

   assign rsp_bus.valid       = (count_ff != 2'd0);
   assign rsp_bus.wheel_left  = mem_ff[rd_ptr_ff].left;
   assign rsp_bus.wheel_front = mem_ff[rd_ptr_ff].front;
   assign rsp_bus.wheel_right = mem_ff[rd_ptr_ff].right;
   assign rsp_bus.wheel_back  = mem_ff[rd_ptr_ff].back;

endmodule

// ----- hw/rtl/omni_wheel_field_oriented_mixer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omni_wheel_field_oriented_mixer
// Rotates a turret-frame velocity command into the chassis frame and mixes
// it into four saturated omni-wheel rpm targets.
// ----------------------------------------------------------------------------
// Pipeline: request register, one CORDIC stage per rotation and a rounding
//   stage, then the mixer, the scaler and the response buffer.
// Throughput: one command per cycle; the pipeline holds only while the
//   two-entry response buffer is full.
// Reset: synchronous; clears all valid bits and the response buffer and
//   loads rpm_scale = 1.0 and arm_length = 1.0. No clearing pass.
// ----------------------------------------------------------------------------
module omni_wheel_field_oriented_mixer
   import owfom_pkg::*;
#(
   parameter int TRIG_BITS = TRIG_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   owfom_req_if.sink   req_bus,
   owfom_rsp_if.source rsp_bus,
   owfom_csr_if.sink   csr_bus
);

   logic [31:0]        rpm_scale_ff;
   logic [15:0]        arm_length_ff;

   logic               en;
   logic               trig_valid;
   cmd_type            trig_cmd;
   logic signed [16:0] trig_cos;
   logic signed [16:0] trig_sin;
   logic               mix_valid;
   sum_type            mix_sum [0:3];
   logic               scale_valid;
   wheels_type         scale_wheels;

   // Register writes; unknown indexes are dropped
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_scale_ff  <= RPM_SCALE_RESET;
         arm_length_ff <= ARM_LENGTH_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_RPM_SCALE:  rpm_scale_ff  <= csr_bus.data;
            REG_ARM_LENGTH: arm_length_ff <= csr_bus.data[15:0];
            default: ;
         endcase
      end
   end

   owfom_cordic #(
      .TRIG_BITS (TRIG_BITS)
   ) u_cordic (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .req_bus    (req_bus),
      .trig_valid (trig_valid),
      .trig_cmd   (trig_cmd),
      .trig_cos   (trig_cos),
      .trig_sin   (trig_sin)
   );

   owfom_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .arm_length (arm_length_ff),
      .trig_valid (trig_valid),
      .trig_cmd   (trig_cmd),
      .trig_cos   (trig_cos),
      .trig_sin   (trig_sin),
      .mix_valid  (mix_valid),
      .mix_sum    (mix_sum)
   );

   owfom_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .rpm_scale    (rpm_scale_ff),
      .mix_valid    (mix_valid),
      .mix_sum      (mix_sum),
      .scale_valid  (scale_valid),
      .scale_wheels (scale_wheels)
   );

   owfom_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (scale_valid),
      .push_wheels (scale_wheels),
      .en          (en),
      .rsp_bus     (rsp_bus)
   );

`ifndef ASSERT_OFF
   // A held pipeline keeps its last stage
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(scale_valid))
      else $error("pipeline last stage changed while held");

   // A result entering the buffer is offered on the next cycle
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (en && scale_valid) |=> rsp_bus.valid)
      else $error("pushed result not offered");

   // The pipeline only holds while results wait in the buffer
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      !en |-> rsp_bus.valid)
      else $error("pipeline held with empty response buffer");
`endif

endmodule
